// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared definitions for the round-robin task scheduler
// Opcodes, sequencer states, field widths and default sizes.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NUM_TASKS_DEF = 5;
	localparam int OP_W          = 2;
	localparam int WORD_W        = 32;
	localparam int TASK_W        = 4;
	localparam logic [WORD_W-1:0] SP_FRAME = 32'd64;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_DELAY = 2'd1,
		OP_LOAD  = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_WAKE,
		ST_DELAY,
		ST_LOAD,
		ST_START,
		ST_SAVE,
		ST_PICK,
		ST_READ,
		ST_RESP
	} state_t;

endpackage

// ===== sv/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
	parameter int WIDTH = rrts_pkg::WORD_W,
	parameter int DEPTH = rrts_pkg::NUM_TASKS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: hardware round-robin task scheduler
// Keeps saved stack pointers, ready flags and wake ticks for a set of task
// slots and picks the next task on each tick, delay or start.
// ----------------------------------------------------------------------------
// The input channel carries one command per transaction: a tick, a delay of
// the current task, a stack load for one slot, or a start. Every input
// transaction produces exactly one output transaction with the task to run
// next, its saved stack pointer and a flag telling whether a switch happened.
// Commands are handled one at a time by a small sequencer; in_ready is high
// only while it is idle.
// A tick goes from ST_TICK to ST_WAKE, which reads the wake tick of every
// slot but slot 0 from the wake-tick RAM and compares it with the tick
// counter, then through ST_SAVE to the round-robin search in ST_PICK, one
// candidate slot per cycle, and on to ST_READ and ST_RESP. A delay runs
// ST_DELAY, ST_SAVE, ST_PICK, ST_READ and ST_RESP, a load or a start its own
// state and then ST_READ and ST_RESP, and a delay from the idle task only
// ST_READ and ST_RESP.
// Reset clears all ready flags, selects task 1 and zeroes the tick counter.
// The stack pointer and wake-tick RAMs are not cleared.
// The result sits in an output register; the next command is accepted while
// it waits, and the sequencer holds its following result until it is taken.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
	parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rrts_pkg::OP_W-1:0]   opcode,
	input  logic [rrts_pkg::WORD_W-1:0] delay_ticks,
	input  logic [rrts_pkg::WORD_W-1:0] running_sp,
	input  logic [rrts_pkg::TASK_W-1:0] task_index,
	input  logic [rrts_pkg::WORD_W-1:0] stack_top,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rrts_pkg::TASK_W-1:0] next_task,
	output logic [rrts_pkg::WORD_W-1:0] next_sp,
	output logic                        switched
);

	import rrts_pkg::*;

	localparam int IW = $clog2(NUM_TASKS);
	localparam int CW = $clog2(NUM_TASKS + 1);

	state_t state_q, state_d;

	logic [WORD_W-1:0]    delay_q;
	logic [WORD_W-1:0]    rsp_q;
	logic [TASK_W-1:0]    idx_q;
	logic [WORD_W-1:0]    top_q;
	logic                 sw_q;

	logic [NUM_TASKS-1:0] ready_q;
	logic [IW-1:0]        current_q;
	logic [WORD_W-1:0]    tick_q;

	logic [CW-1:0]        scan_q;
	logic [IW-1:0]        cmp_idx_s1;
	logic                 cmp_vld_s1;
	logic [IW-1:0]        pick_q;
	logic [CW-1:0]        steps_q;

	logic                 out_valid_q;
	logic [TASK_W-1:0]    next_task_q;
	logic [WORD_W-1:0]    next_sp_q;
	logic                 switched_q;

	logic                 in_acc;
	logic                 scan_done;
	logic                 idx_ok;
	logic [IW-1:0]        cand;
	logic                 hit;
	logic                 pick_last;
	logic                 out_free;

	logic                 sp_we;
	logic [IW-1:0]        sp_waddr;
	logic [WORD_W-1:0]    sp_wdata;
	logic [WORD_W-1:0]    sp_rdata;
	logic                 wk_we;
	logic [IW-1:0]        wk_raddr;
	logic [WORD_W-1:0]    wk_rdata;

	assign in_acc    = in_valid && in_ready;
	assign scan_done = (scan_q == CW'(NUM_TASKS));
	assign idx_ok    = ({1'b0, idx_q} < (TASK_W + 1)'(NUM_TASKS));
	assign cand      = (pick_q == IW'(NUM_TASKS - 1)) ? '0 : pick_q + 1'b1;
	assign hit       = (cand != '0) && ready_q[cand];
	assign pick_last = (steps_q == CW'(NUM_TASKS - 1));
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(opcode))
						OP_TICK:  state_d = ST_TICK;
						OP_DELAY: state_d = (current_q == '0) ? ST_READ : ST_DELAY;
						OP_LOAD:  state_d = ST_LOAD;
						OP_START: state_d = ST_START;
					endcase
				end
			end
			ST_TICK:  state_d = ST_WAKE;
			ST_WAKE:  state_d = scan_done ? ST_SAVE : ST_WAKE;
			ST_DELAY: state_d = ST_SAVE;
			ST_LOAD:  state_d = ST_READ;
			ST_START: state_d = ST_READ;
			ST_SAVE:  state_d = ST_PICK;
			ST_PICK:  state_d = (hit || pick_last) ? ST_READ : ST_PICK;
			ST_READ:  state_d = ST_RESP;
			ST_RESP:  state_d = out_free ? ST_IDLE : ST_RESP;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		sp_we    = 1'b0;
		sp_waddr = current_q;
		sp_wdata = rsp_q;
		wk_we    = (state_q == ST_DELAY);
		wk_raddr = scan_done ? '0 : scan_q[IW-1:0];
		unique case (state_q)
			ST_SAVE: begin
				sp_we = 1'b1;
			end
			ST_LOAD: begin
				sp_we    = idx_ok;
				sp_waddr = idx_q[IW-1:0];
				sp_wdata = top_q - SP_FRAME;
			end
			default: begin
			end
		endcase
	end

	rrts_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_TASKS)
	) u_sp_ram (
		.clk  (clk),
		.we   (sp_we),
		.waddr(sp_waddr),
		.wdata(sp_wdata),
		.raddr(current_q),
		.rdata(sp_rdata)
	);

	rrts_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_TASKS)
	) u_wake_ram (
		.clk  (clk),
		.we   (wk_we),
		.waddr(current_q),
		.wdata(tick_q + delay_q),
		.raddr(wk_raddr),
		.rdata(wk_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			delay_q <= delay_ticks;
			rsp_q   <= running_sp;
			idx_q   <= task_index;
			top_q   <= stack_top;
			sw_q    <= !((op_t'(opcode) == OP_LOAD) ||
				((op_t'(opcode) == OP_DELAY) && (current_q == '0)));
		end
		if (state_q == ST_SAVE) begin
			pick_q  <= current_q;
			steps_q <= '0;
		end else if (state_q == ST_PICK) begin
			pick_q  <= cand;
			steps_q <= steps_q + 1'b1;
		end
		cmp_idx_s1 <= scan_q[IW-1:0];
		if ((state_q == ST_RESP) && out_free) begin
			next_task_q <= TASK_W'(current_q);
			next_sp_q   <= sw_q ? sp_rdata : '0;
			switched_q  <= sw_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= '0;
			current_q   <= IW'(1);
			tick_q      <= '0;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_TICK: begin
					tick_q     <= tick_q + 1'b1;
					scan_q     <= CW'(1);
					cmp_vld_s1 <= 1'b0;
				end
				ST_WAKE: begin
					cmp_vld_s1 <= !scan_done;
					if (!scan_done) begin
						scan_q <= scan_q + 1'b1;
					end
					if (cmp_vld_s1 && !ready_q[cmp_idx_s1] && (wk_rdata == tick_q)) begin
						ready_q[cmp_idx_s1] <= 1'b1;
					end
				end
				ST_DELAY: begin
					ready_q[current_q] <= 1'b0;
				end
				ST_LOAD: begin
					if (idx_ok) begin
						ready_q[idx_q[IW-1:0]] <= 1'b1;
					end
				end
				ST_START: begin
					current_q <= IW'(1);
				end
				ST_PICK: begin
					if (hit) begin
						current_q <= cand;
					end else if (pick_last) begin
						current_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign next_task = next_task_q;
	assign next_sp   = next_sp_q;
	assign switched  = switched_q;

	a_no_switch_zero_sp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !switched |-> next_sp == '0)
		else $error("Result without a switch carries a nonzero stack pointer.");

	a_task_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, next_task} < (TASK_W + 1)'(NUM_TASKS))
		else $error("Result names a task slot that does not exist.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Scheduler took a second transaction while busy.");

	a_current_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, current_q} < (IW + 1)'(NUM_TASKS))
		else $error("Current task index left the slot range.");

endmodule
